// File: design/amg_classical_strength_filter_assert.svh
// assertion macros used by the strength filter datapath
`ifndef AMG_CLASSICAL_STRENGTH_FILTER_ASSERT_SVH
`define AMG_CLASSICAL_STRENGTH_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AMGCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AMGCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/amgcs_pkg.sv
// shared constants and control types of the strength filter
package amgcs_pkg;

    localparam int MAX_ROW_ENTRIES = 32;
    localparam int INDEX_BITS      = 20;
    localparam int VAL_W           = 32;
    localparam int VAR_W           = 8;
    localparam int THETA_W         = 16;
    localparam int CNT_W           = $clog2(MAX_ROW_ENTRIES + 1);
    localparam int ADDR_W          = $clog2(MAX_ROW_ENTRIES);
    localparam int PROD_W          = VAL_W + THETA_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THETA_W;
    localparam logic [CFG_IDX_W-1:0] CFG_THETA    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_VARS = 1'd1;
    localparam logic [THETA_W-1:0]   THETA_RESET  = 16'd16384;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // item offered to the row buffer, dropped once the buffer is full
        logic scan_rst;   // rewind the buffer scan to the first off-diagonal
        logic ext_scan;   // extreme search pass
        logic mul;        // form the threshold, stage the diagonal
        logic flt_scan;   // filter pass
        logic flush;      // release the held result and clear the row
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } status_t;

endpackage

// File: design/amg_classical_strength_filter.sv
// strength-of-connection filter for one sparse matrix row: top level
// Entries of a row are taken one per cycle while busy is low (start high, busy low).
// The entry with last_in_row high starts processing: busy then stays high through a scan
// setup, an extreme search pass over the single read port of the row buffer, a threshold
// multiply, a filter pass over the same port and a flush. Kept entries are issued during
// the filter pass, the last one as busy falls, each for one cycle with result_strobe high;
// the receiver cannot stall them. The diagonal (if stored) comes first and last_of_row
// marks the final kept entry. Rows with more than 32 entries drop the extra ones and
// report overflow on every result.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while idle;
// the block itself does not enforce this.
module amg_classical_strength_filter
    import amgcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [INDEX_BITS-1:0]   row_index,
    input  logic [INDEX_BITS-1:0]   col_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic [VAR_W-1:0]        row_var,
    input  logic [VAR_W-1:0]        col_var,
    input  logic                    last_in_row,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    result_strobe,
    output logic [INDEX_BITS-1:0]   out_row,
    output logic [INDEX_BITS-1:0]   out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    last_of_row,
    output logic                    overflow
);

    logic [THETA_W-1:0] theta_reg;
    logic               use_vars_reg;
    cmd_t               cmd;
    status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg    <= THETA_RESET;
            use_vars_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THETA:
                begin
                    theta_reg <= cfg_data[THETA_W-1:0];
                end
                CFG_USE_VARS:
                begin
                    use_vars_reg <= cfg_data[0];
                end
                default:
                begin
                    theta_reg <= theta_reg;
                end
            endcase
        end
    end

    amgcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_in_row (last_in_row),
        .status      (status),
        .busy        (busy),
        .cmd         (cmd)
    );

    amgcs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .row_var       (row_var),
        .col_var       (col_var),
        .theta         (theta_reg),
        .use_variables (use_vars_reg),
        .result_strobe (result_strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last_of_row   (last_of_row),
        .overflow      (overflow)
    );

endmodule

// File: design/amgcs_ctrl.sv
// row sequencer: loading, extreme pass, threshold, filter pass, flush
module amgcs_ctrl
    import amgcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_in_row,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_EXT   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_FLT   = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                if (start && last_in_row)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.scan_rst = 1'b1;
                state_next   = ST_EXT;
            end
            ST_EXT:
            begin
                cmd.ext_scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul      = 1'b1;
                cmd.scan_rst = 1'b1;
                state_next   = ST_FLT;
            end
            ST_FLT:
            begin
                cmd.flt_scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: design/amgcs_dp.sv
// row buffer, extreme search, threshold multiply and result staging
module amgcs_dp
    import amgcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [INDEX_BITS-1:0] row_index,
    input  logic [INDEX_BITS-1:0] col_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic [VAR_W-1:0]      row_var,
    input  logic [VAR_W-1:0]      col_var,
    input  logic [THETA_W-1:0]    theta,
    input  logic                  use_variables,
    output logic                  result_strobe,
    output logic [INDEX_BITS-1:0] out_row,
    output logic [INDEX_BITS-1:0] out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic                  last_of_row,
    output logic                  overflow
);

    `include "amg_classical_strength_filter_assert.svh"

    // row buffer
    logic [INDEX_BITS-1:0] col_mem [MAX_ROW_ENTRIES];
    logic [VAL_W-1:0]      val_mem [MAX_ROW_ENTRIES];
    logic                  flag_mem [MAX_ROW_ENTRIES];

    logic [CNT_W-1:0]      cnt_reg;
    logic [INDEX_BITS-1:0] row_reg;
    logic                  diag_present_reg;
    logic                  diag_neg_reg;
    logic signed [VAL_W-1:0] diag_val_reg;
    logic                  ovf_reg;

    logic [CNT_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;
    logic [INDEX_BITS-1:0] rd_col_reg;
    logic signed [VAL_W-1:0] rd_val_reg;
    logic                  rd_flag_reg;

    logic signed [VAL_W-1:0]  ext_reg;
    logic                     ext_vld_reg;
    logic signed [PROD_W-1:0] thr_reg;

    logic [INDEX_BITS-1:0]   pend_col_reg;
    logic signed [VAL_W-1:0] pend_val_reg;
    logic                    pend_vld_reg;

    logic                  strobe_reg;
    logic [INDEX_BITS-1:0] res_col_reg;
    logic signed [VAL_W-1:0] res_val_reg;
    logic                  res_last_reg;
    logic [INDEX_BITS-1:0] res_row_reg;
    logic                  res_ovf_reg;

    logic                     wr_en;
    logic                     issue;
    logic                     cand;
    logic                     ext_better;
    logic                     keep;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] v_scaled;

    assign wr_en  = cmd.load && (cnt_reg < CNT_W'(MAX_ROW_ENTRIES));
    assign issue  = (cmd.ext_scan || cmd.flt_scan) && (rd_idx_reg < cnt_reg);
    assign status.scan_done = (rd_idx_reg == cnt_reg) && !rd_vld_reg;

    assign cand       = !(use_variables && !rd_flag_reg);
    assign ext_better = diag_neg_reg ? (rd_val_reg > ext_reg) : (rd_val_reg < ext_reg);
    assign prod       = $signed(ext_reg) * $signed({1'b0, theta});
    assign v_scaled   = {rd_val_reg[VAL_W-1], rd_val_reg, {THETA_W{1'b0}}};
    assign keep       = cand && (diag_neg_reg ? (v_scaled > thr_reg) : (v_scaled < thr_reg));

    // buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[cnt_reg[ADDR_W-1:0]]  <= col_index;
            val_mem[cnt_reg[ADDR_W-1:0]]  <= entry_value;
            flag_mem[cnt_reg[ADDR_W-1:0]] <= (row_var == col_var);
        end
        if (issue)
        begin
            rd_col_reg  <= col_mem[rd_idx_reg[ADDR_W-1:0]];
            rd_val_reg  <= val_mem[rd_idx_reg[ADDR_W-1:0]];
            rd_flag_reg <= flag_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    // row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            diag_present_reg <= 1'b0;
            diag_neg_reg     <= 1'b0;
            ovf_reg          <= 1'b0;
        end
        else if (cmd.flush)
        begin
            cnt_reg          <= '0;
            diag_present_reg <= 1'b0;
            diag_neg_reg     <= 1'b0;
            ovf_reg          <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (cnt_reg == '0)
            begin
                diag_present_reg <= (col_index == row_index);
                diag_neg_reg     <= (col_index == row_index) && entry_value[VAL_W-1];
            end
            if (wr_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (cnt_reg == '0))
        begin
            row_reg      <= row_index;
            diag_val_reg <= entry_value;
        end
    end

    // scan pointer and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            ext_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (cmd.scan_rst)
            begin
                rd_idx_reg <= diag_present_reg ? CNT_W'(1) : CNT_W'(0);
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (cmd.scan_rst && !cmd.mul)
            begin
                ext_vld_reg <= 1'b0;
            end
            else if (cmd.ext_scan && rd_vld_reg && cand)
            begin
                ext_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= '0;
        end
        else if (cmd.flush)
        begin
            ext_reg <= '0;
        end
        else if (cmd.ext_scan && rd_vld_reg && cand && (!ext_vld_reg || ext_better))
        begin
            ext_reg <= rd_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            thr_reg <= prod;
        end
    end

    // one result is held back so the final one can carry last_of_row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cmd.mul)
            begin
                pend_vld_reg <= diag_present_reg;
            end
            else if (cmd.flt_scan && rd_vld_reg && keep)
            begin
                pend_vld_reg <= 1'b1;
                strobe_reg   <= pend_vld_reg;
                res_last_reg <= 1'b0;
            end
            else if (cmd.flush)
            begin
                pend_vld_reg <= 1'b0;
                strobe_reg   <= pend_vld_reg;
                res_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pend_col_reg <= row_reg;
            pend_val_reg <= diag_val_reg;
        end
        else if (cmd.flt_scan && rd_vld_reg && keep)
        begin
            pend_col_reg <= rd_col_reg;
            pend_val_reg <= rd_val_reg;
        end
        if ((cmd.flt_scan && rd_vld_reg && keep) || cmd.flush)
        begin
            res_col_reg <= pend_col_reg;
            res_val_reg <= pend_val_reg;
            res_row_reg <= row_reg;
            res_ovf_reg <= ovf_reg;
        end
    end

    assign result_strobe = strobe_reg;
    assign out_row       = res_row_reg;
    assign out_col       = res_col_reg;
    assign out_value     = res_val_reg;
    assign last_of_row   = res_last_reg;
    assign overflow      = res_ovf_reg;

    `AMGCS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_ROW_ENTRIES), "row count past buffer depth")
    `AMGCS_ASSERT_NEXT(a_flush_clears, clk, rst_n, cmd.flush, (cnt_reg == '0) && !pend_vld_reg, "row state not cleared after flush")
    `AMGCS_ASSERT_NOW(a_read_in_scan, clk, rst_n, rd_vld_reg, cmd.ext_scan || cmd.flt_scan, "buffer read data outside a scan pass")
    `AMGCS_ASSERT_NOW(a_no_load_in_scan, clk, rst_n, cmd.ext_scan || cmd.flt_scan, !cmd.load, "item loaded during a scan pass")

endmodule
